### src/sorted_key_value_table_unit_assert.svh
// Assertion macros shared by the sorted key-value table RTL.
`ifndef SORTED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SKV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication, disabled during reset.
`define SKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

### src/skv_pkg.sv
// Package: sizes, codes and cell control type for the sorted key-value table.
package skv_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // fixed field widths of the channels
    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic cmp;   // latch compare flags against the held key
        logic ins;   // insert the held entry at its sorted place
        logic rem;   // remove the hit entry and close the gap
    } cell_ctl_t;

endpackage

### src/skv_req_if.sv
// Request channel: opcode, key and value with valid/ready.
interface skv_req_if import skv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

### src/skv_rsp_if.sv
// Response channel: status, value and entry count with valid/ready.
interface skv_rsp_if import skv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output value_out, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input value_out, input entry_count,
                    output ready);
endinterface

### src/skv_cell.sv
// One slot of the sorted chain: holds a key/value, compares and shifts with neighbours.
module skv_cell import skv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctl_t             ctl,
    input  logic                  occ,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic                  lt_left,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic [KEY_BITS-1:0]   right_key,
    input  logic [VALUE_BITS-1:0] right_value,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value,
    output logic                  lt,
    output logic                  eq
);

    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  lt_reg, lt_next;
    logic                  eq_reg, eq_next;

    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctl.cmp)
        begin
            lt_next = occ && (key_reg < new_key);
            eq_next = occ && (key_reg == new_key);
        end
    end

    // slots below the insert/remove point keep their entry
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        priority if (ctl.ins && !lt_reg)
        begin
            if (lt_left)
            begin
                key_next   = new_key;
                value_next = new_value;
            end
            else
            begin
                key_next   = left_key;
                value_next = left_value;
            end
        end
        else if (ctl.rem && !lt_reg)
        begin
            key_next   = right_key;
            value_next = right_value;
        end
        else
        begin
            key_next   = key_reg;
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

### src/sorted_key_value_table_unit.sv
// A request accepted in idle passes a compare phase, then an apply phase that registers its response.
// Ready is low while a request is in work, so no new request is taken before the last one is done.
// A stalled response holds the request in its apply phase until the output slot frees.
// The two phases match the compare step and the shift step of the cell chain.
// Reset empties the table at once; entry contents are left as they are, no clearing pass.
module sorted_key_value_table_unit import skv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    skv_req_if.sink    req,
    skv_rsp_if.source  rsp
);

`include "sorted_key_value_table_unit_assert.svh"

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CMP   = 2'd1;
    localparam logic [1:0] PH_APPLY = 2'd2;

    logic [1:0]            phase_reg, phase_next;
    logic [OPCODE_W-1:0]   op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [VALUE_W-1:0]    value_out_reg, value_out_next;
    logic [COUNT_W-1:0]    count_out_reg, count_out_next;

    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   lt_vec;
    logic [CAPACITY-1:0]   eq_vec;
    logic [CAPACITY-1:0]   occ_vec;

    logic                  req_fire;
    logic                  apply_go;
    logic                  full;
    logic                  hit;
    logic [VALUE_BITS-1:0] hit_value;
    cell_ctl_t             ctl;

    assign req.ready = (phase_reg == PH_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign apply_go  = (phase_reg == PH_APPLY) && (!out_valid_reg || rsp.ready);
    assign full      = (count_reg == COUNT_BITS'(CAPACITY));

    always_comb
    begin
        hit       = 1'b0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit       = hit | eq_vec[i];
            hit_value = hit_value | (eq_vec[i] ? cell_value[i] : '0);
        end
    end

    always_comb
    begin
        ctl.cmp = (phase_reg == PH_CMP);
        ctl.ins = apply_go && (op_reg == OP_ADD) && !full && !hit;
        ctl.rem = apply_go && (op_reg == OP_REMOVE) && hit;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                  lt_left;
            logic [KEY_BITS-1:0]   left_key, right_key;
            logic [VALUE_BITS-1:0] left_value, right_value;

            assign occ_vec[gi] = (COUNT_BITS'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign lt_left    = 1'b1;
                assign left_key   = '0;
                assign left_value = '0;
            end
            else
            begin : g_mid
                assign lt_left    = lt_vec[gi-1];
                assign left_key   = cell_key[gi-1];
                assign left_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_key   = '0;
                assign right_value = '0;
            end
            else
            begin : g_inner
                assign right_key   = cell_key[gi+1];
                assign right_value = cell_value[gi+1];
            end

            skv_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .occ         (occ_vec[gi]),
                .new_key     (key_reg),
                .new_value   (value_reg),
                .lt_left     (lt_left),
                .left_key    (left_key),
                .left_value  (left_value),
                .right_key   (right_key),
                .right_value (right_value),
                .key         (cell_key[gi]),
                .value       (cell_value[gi]),
                .lt          (lt_vec[gi]),
                .eq          (eq_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:  if (req_fire) phase_next = PH_CMP;
            PH_CMP:   phase_next = PH_APPLY;
            PH_APPLY: if (apply_go) phase_next = PH_IDLE;
            default:  phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
            count_next = count_reg + COUNT_BITS'(1);
        else if (ctl.rem)
            count_next = count_reg - COUNT_BITS'(1);
    end

    always_comb
    begin
        status_next    = ST_MISS;
        value_out_next = '0;
        unique case (op_reg)
            OP_ADD:
            begin
                if (full)
                    status_next = ST_FULL;
                else if (!hit)
                    status_next = ST_OK;
            end
            OP_LOOKUP, OP_REMOVE:
            begin
                if (hit)
                begin
                    status_next    = ST_OK;
                    value_out_next = VALUE_W'(hit_value);
                end
            end
            default: status_next = ST_MISS;
        endcase
        count_out_next = COUNT_W'(count_next);

        out_valid_next = out_valid_reg;
        if (apply_go)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg    <= req.opcode;
            key_reg   <= KEY_BITS'(req.key);
            value_reg <= VALUE_BITS'(req.value);
        end
        if (apply_go)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
            count_out_reg <= count_out_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.value_out   = value_out_reg;
    assign rsp.entry_count = count_out_reg;

    `SKV_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= COUNT_BITS'(CAPACITY))
    `SKV_ASSERT_IMPL(a_lt_prefix, phase_reg == PH_APPLY, ((lt_vec >> 1) & ~lt_vec) == '0)
    `SKV_ASSERT_IMPL(a_single_hit, phase_reg == PH_APPLY, $onehot0(eq_vec))
    `SKV_ASSERT_NEXT(a_fire_to_cmp, req_fire, phase_reg == PH_CMP)
    `SKV_ASSERT_IMPL(a_one_change, 1'b1, !(ctl.ins && ctl.rem))

endmodule

### test/sorted_key_value_table_unit_test.sv
// Testbench for the sorted key-value table: random and directed requests against a shadow table.
module sorted_key_value_table_unit_test import skv_pkg::*;;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [VALUE_W-1:0] VALUE_MASK =
        (VALUE_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : ((32'd1 << VALUE_BITS) - 32'd1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value_out;
        logic [COUNT_W-1:0]  entry_count;
    } kv_response_t;

    logic clk;
    logic rst_n;

    skv_req_if req_ch ();
    skv_rsp_if rsp_ch ();

    sorted_key_value_table_unit DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the table contents
    logic [KEY_W-1:0]   shadow_keys   [CAPACITY];
    logic [VALUE_W-1:0] shadow_values [CAPACITY];
    int                 shadow_count;

    kv_response_t awaited_responses [$];
    int           error_count;
    bit           idle_on;
    int           hold_off_left;
    int           cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one request to the shadow table and returns the response it should give.
    function automatic kv_response_t shadow_table_op(input logic [OPCODE_W-1:0] op,
                                                     input logic [KEY_W-1:0] key_in,
                                                     input logic [VALUE_W-1:0] value_in);
        kv_response_t result;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
        int pos;
        bit hit;
        k = key_in & KEY_MASK;
        v = value_in & VALUE_MASK;
        result.status = ST_MISS;
        result.value_out = '0;
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < k)
            pos++;
        hit = (pos < shadow_count) && (shadow_keys[pos] == k);
        case (op)
            OP_ADD:
            begin
                // full takes precedence over duplicate
                if (shadow_count >= CAPACITY)
                    result.status = ST_FULL;
                else if (!hit)
                begin
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_keys[i]   = shadow_keys[i-1];
                        shadow_values[i] = shadow_values[i-1];
                    end
                    shadow_keys[pos]   = k;
                    shadow_values[pos] = v;
                    shadow_count++;
                    result.status = ST_OK;
                end
            end
            OP_LOOKUP:
            begin
                if (hit)
                begin
                    result.status = ST_OK;
                    result.value_out = shadow_values[pos];
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    result.status = ST_OK;
                    result.value_out = shadow_values[pos];
                    for (int i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i]   = shadow_keys[i+1];
                        shadow_values[i] = shadow_values[i+1];
                    end
                    shadow_count--;
                end
            end
            default:
            begin
                result.status = ST_MISS;
            end
        endcase
        result.entry_count = shadow_count[COUNT_W-1:0];
        return result;
    endfunction

    // Text key: up to eight bytes, big-endian, zero padded.
    function automatic logic [KEY_W-1:0] pack_text(input string s);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            k[63 - 8*i -: 8] = s[i];
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] random_text_key();
        logic [KEY_W-1:0] k;
        int len;
        k = '0;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                k[63 - 8*i -: 8] = 8'($urandom_range(1, 255));
            else
                k[63 - 8*i -: 8] = 8'($urandom_range(97, 100));   // narrow alphabet, more hits
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        else if (r < 70)
            return random_text_key();
        else if (r < 85)
            return {$urandom, $urandom};
        else if (r < 90)
            return '0;
        else if (r < 95)
            return '1;
        else if (shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)] + 64'd1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] k,
                                input logic [VALUE_W-1:0] v);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.key    <= k;
        req_ch.value  <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        awaited_responses.push_back(shadow_table_op(op, k, v));
    endtask

    task automatic wait_for_responses();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_responses.size() != 0);
    endtask

    task automatic test_directed();
        idle_on = 1'b0;
        send_request(OP_LOOKUP, '0, '0);
        send_request(OP_REMOVE, '1, '1);
        send_request(OP_UNUSED, 64'd5, 32'd7);
        send_request(OP_ADD, pack_text("m"), 32'h1234_5678);
        send_request(OP_ADD, '0, '0);
        send_request(OP_ADD, '1, '1);
        send_request(OP_ADD, pack_text("ab"), 32'hAAAA_5555);
        send_request(OP_ADD, pack_text("abc"), 32'h5555_AAAA);
        send_request(OP_ADD, pack_text("m"), 32'hDEAD_BEEF);
        send_request(OP_LOOKUP, '0, '1);
        send_request(OP_LOOKUP, '1, '0);
        send_request(OP_LOOKUP, pack_text("ab"), '0);
        send_request(OP_LOOKUP, pack_text("abd"), '0);
        send_request(OP_UNUSED, pack_text("ab"), '1);
        send_request(OP_REMOVE, pack_text("m"), '0);
        send_request(OP_LOOKUP, pack_text("m"), '0);
        send_request(OP_REMOVE, '0, '0);
        send_request(OP_REMOVE, '1, '0);
        send_request(OP_REMOVE, pack_text("ab"), '0);
        send_request(OP_ADD, 64'h8000_0000_0000_0000, 32'd1);
        send_request(OP_REMOVE, pack_text("abc"), '0);
        send_request(OP_REMOVE, 64'h8000_0000_0000_0000, '0);
        send_request(OP_ADD, pack_text("zzzzzzzz"), 32'h5A5A_5A5A);
        send_request(OP_REMOVE, pack_text("zzzzzzzz"), '0);
        wait_for_responses();
    endtask

    // fill to capacity, hit the full case, then drain to empty
    task automatic test_full_table();
        logic [KEY_W-1:0] k;
        idle_on = 1'b1;
        while (shadow_count < CAPACITY)
        begin
            k = ($urandom_range(0, 1) == 0) ? random_text_key() : {$urandom, $urandom};
            send_request(OP_ADD, k, pick_value());
        end
        // duplicate key on a full table still reports full
        send_request(OP_ADD, shadow_keys[$urandom_range(0, CAPACITY - 1)], pick_value());
        send_request(OP_ADD, '0, '0);
        send_request(OP_ADD, '1, '1);
        send_request(OP_LOOKUP, shadow_keys[0], '0);
        send_request(OP_LOOKUP, shadow_keys[CAPACITY - 1], '0);
        while (shadow_count > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(OP_REMOVE, {$urandom, $urandom}, pick_value());
            else
                send_request(OP_REMOVE, shadow_keys[$urandom_range(0, shadow_count - 1)],
                             pick_value());
        end
        wait_for_responses();
    endtask

    task automatic test_random_mix(input int n_items, input bit with_idle);
        int r;
        int add_weight;
        logic [OPCODE_W-1:0] op;
        idle_on = with_idle;
        for (int i = 0; i < n_items; i++)
        begin
            add_weight = (shadow_count < 48) ? 45 : 25;
            r = $urandom_range(0, 99);
            if (r < add_weight)
                op = OP_ADD;
            else if (r < add_weight + 25)
                op = OP_LOOKUP;
            else if (r < 95)
                op = OP_REMOVE;
            else
                op = OP_UNUSED;
            send_request(op, pick_key(), pick_value());
        end
        wait_for_responses();
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_back_pressure();
        idle_on = 1'b0;
        hold_off_left = 150;
        for (int i = 0; i < 30; i++)
            send_request(($urandom_range(0, 1) == 0) ? OP_ADD : OP_LOOKUP, pick_key(),
                         pick_value());
        wait_for_responses();
    endtask

    // response side: checks each response, stalls at random or for a hold-off
    initial
    begin : response_side
        int stall_left;
        kv_response_t want;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    $error("response with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %0h, actual %0h", want.value_out,
                               rsp_ch.value_out);
                        error_count++;
                    end
                    if (rsp_ch.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d", want.entry_count,
                               rsp_ch.entry_count);
                        error_count++;
                    end
                end
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                rsp_ch.ready <= (stall_left == 0);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        error_count   = 0;
        idle_on       = 1'b0;
        hold_off_left = 0;
        shadow_count  = 0;
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.opcode <= OP_ADD;
        req_ch.key    <= '0;
        req_ch.value  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random_mix(500, 1'b1);
        test_back_pressure();
        test_random_mix(300, 1'b0);
        test_random_mix(250, 1'b1);

        idle_on = 1'b0;
        repeat (10) @(posedge clk);
        if (awaited_responses.size() != 0)
        begin
            $error("%0d responses never arrived", awaited_responses.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/skv_pkg.sv
src/skv_req_if.sv
src/skv_rsp_if.sv
src/skv_cell.sv
src/sorted_key_value_table_unit.sv
test/sorted_key_value_table_unit_test.sv
